>>> rtl/core/tdpt_pkg.sv
// shared types for the trial division prime test: controller states and control structs
`timescale 1ns / 1ps
`default_nettype none
package tdpt_pkg;

    // controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_TEST   = 4'b1000
    } tdpt_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture the number, divisor back to two
        logic div_init;  // clear remainder, point at the top bit
        logic div_step;  // one restoring step of the remainder
        logic next_div;  // advance divisor and its square
        logic finish;    // register the verdict
        logic verdict;   // prime flag to register on finish
    } tdpt_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic lt_two;    // number is zero or one
        logic sq_gt_n;   // divisor squared exceeds number
        logic div_last;  // current step works on bit zero
        logic rem_zero;  // remainder is zero
    } tdpt_status_t;

endpackage
`default_nettype wire

>>> rtl/core/tdpt_datapath.sv
// datapath: number, trial divisor, its square and a bit-serial remainder unit
`timescale 1ns / 1ps
`default_nettype none
module tdpt_datapath #(
    parameter int NUM_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic [NUM_WIDTH-1:0]  value,
    input  wire tdpt_pkg::tdpt_cmd_t   cmd,
    output      tdpt_pkg::tdpt_status_t status,
    output      logic                  is_prime
);
    import tdpt_pkg::*;

    localparam int SQ_W  = 2 * NUM_WIDTH;
    localparam int CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

    logic [NUM_WIDTH-1:0] n_reg,   n_next;
    logic [NUM_WIDTH-1:0] d_reg,   d_next;
    logic [SQ_W-1:0]      sq_reg,  sq_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 is_prime_reg, is_prime_next;

    logic [NUM_WIDTH:0]   shifted;
    logic [NUM_WIDTH:0]   trial;

    // restoring step: shift in the next bit of the number, subtract if it fits
    assign shifted = {rem_reg, n_reg[cnt_reg]};
    assign trial   = shifted - {1'b0, d_reg};

    always_comb
    begin
        n_next        = n_reg;
        d_next        = d_reg;
        sq_next       = sq_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        is_prime_next = is_prime_reg;
        if (cmd.load)
        begin
            n_next  = value;
            d_next  = NUM_WIDTH'(2);
            sq_next = SQ_W'(4);
        end
        if (cmd.div_init)
        begin
            rem_next = '0;
            cnt_next = CNT_W'(NUM_WIDTH - 1);
        end
        if (cmd.div_step)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                rem_next = trial[NUM_WIDTH-1:0];
            end
            else
            begin
                rem_next = shifted[NUM_WIDTH-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (cmd.next_div)
        begin
            // (d+1)^2 = d^2 + 2d + 1
            d_next  = d_reg + NUM_WIDTH'(1);
            sq_next = sq_reg + SQ_W'({d_reg, 1'b0}) + SQ_W'(1);
        end
        if (cmd.finish)
        begin
            is_prime_next = cmd.verdict;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        sq_reg       <= sq_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        is_prime_reg <= is_prime_next;
    end

    assign status.lt_two   = (n_reg < NUM_WIDTH'(2));
    assign status.sq_gt_n  = (sq_reg > {{NUM_WIDTH{1'b0}}, n_reg});
    assign status.div_last = (cnt_reg == '0);
    assign status.rem_zero = (rem_reg == '0);
    assign is_prime        = is_prime_reg;

endmodule
`default_nettype wire

>>> rtl/core/tdpt_ctrl.sv
// controller: sequences divisor checks and remainder steps, raises the done strobe
`timescale 1ns / 1ps
`default_nettype none
module tdpt_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire tdpt_pkg::tdpt_status_t status,
    output      tdpt_pkg::tdpt_cmd_t    cmd,
    output      logic                   busy,
    output      logic                   done
);
    import tdpt_pkg::*;

    tdpt_state_t state_reg, state_next;
    logic        done_reg,  done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                priority if (status.lt_two)
                begin
                    cmd.finish  = 1'b1;
                    cmd.verdict = 1'b0;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (status.sq_gt_n)
                begin
                    cmd.finish  = 1'b1;
                    cmd.verdict = 1'b1;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (status.rem_zero)
                begin
                    cmd.finish  = 1'b1;
                    cmd.verdict = 1'b0;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

>>> rtl/core/trial_division_prime_test.sv
// top level of the trial division prime test: controller plus datapath
`timescale 1ns / 1ps
`default_nettype none
// usage
// - a transaction is taken at a rising edge with start high and busy low; value is
//   captured there and may change afterwards
// - busy stays high while the number is under test; start is ignored meanwhile
// - the verdict appears on is_prime and holds until the next verdict; done marks
//   it for exactly one cycle; the receiver cannot stall, so it must take the
//   result in that cycle
// - numbers below two finish at once; otherwise each trial divisor d = 2, 3, 4
//   and so on takes a check, NUM_WIDTH remainder steps and a test, and the search
//   ends when d*d exceeds the number or a divisor is found; the remainder unit
//   works one bit per cycle
// - one transaction at a time; a new one may be taken in the cycle done is high
// - reset clears the controller to idle with done low; no state carries over
//   between transactions
module trial_division_prime_test #(
    parameter int NUM_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [NUM_WIDTH-1:0] value,
    output      logic                 busy,
    output      logic                 done,
    output      logic                 is_prime
);
    import tdpt_pkg::*;

    tdpt_cmd_t    cmd;
    tdpt_status_t status;

    // sequencer
    tdpt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // number, divisor, square and remainder unit
    tdpt_datapath #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .value    (value),
        .cmd      (cmd),
        .status   (status),
        .is_prime (is_prime)
    );

    // a result strobe lasts one cycle only
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");

    // the block is idle whenever a result is shown
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // an accepted transaction makes the block busy and gives no result at once
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy && !done))
        else $error("accepted transaction did not start work");

endmodule
`default_nettype wire

>>> bench/tb.sv
// self-checking testbench for the trial division prime test, with a small verdict scoreboard
`timescale 1ns / 1ps

typedef logic [15:0] number_t;

// keeps the verdicts still owed by the block, in the order the numbers went in
class verdict_board;
    number_t     number_q[$];
    bit          verdict_q[$];
    int unsigned faults;

    function new();
        faults = 0;
    endfunction

    // exactly two divisors: only divisors up to the square root need trying
    function bit prime_verdict(number_t n);
        int unsigned d;
        if (n < 2)
            return 1'b0;
        for (d = 2; d * d <= n; d++)
            if ((n % d) == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    function void note_number(number_t n);
        number_q.push_back(n);
        verdict_q.push_back(prime_verdict(n));
    endfunction

    function void check_verdict(logic got);
        number_t n;
        bit      want;
        if (verdict_q.size() == 0)
        begin
            $error("is_prime: expected none, actual %0b", got);
            faults++;
            return;
        end
        n    = number_q.pop_front();
        want = verdict_q.pop_front();
        if (got !== want)
        begin
            $error("is_prime: expected %0b, actual %0b (value %0d)", want, got, n);
            faults++;
        end
    endfunction

    function int unsigned pending();
        return verdict_q.size();
    endfunction
endclass

module tb;

    localparam int NUM_WIDTH = 16;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic [NUM_WIDTH-1:0] value;
    logic                 busy;
    logic                 done;
    logic                 is_prime;

    verdict_board board = new();

    // corner numbers: zero and one, the smallest primes, squares of primes and of 255 right on the
    // square-root bound, the largest primes and composites of the range, single-bit and
    // alternating patterns
    number_t corner_values [0:19] = '{
        16'd0,     16'd1,     16'd2,     16'd3,     16'd4,
        16'd5,     16'd9,     16'd25,    16'd49,    16'd63001,
        16'd65025, 16'd65521, 16'd65519, 16'd65535, 16'd32768,
        16'd32749, 16'hAAAA,  16'h5555,  16'd256,   16'd257
    };

    trial_division_prime_test #(
        .NUM_WIDTH(NUM_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .value    (value),
        .busy     (busy),
        .done     (done),
        .is_prime (is_prime)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // generous overall limit; the slowest correct run is well under a fifth of this
    initial
    begin
        #50_000_000;
        $display("trial_division_prime_test: mismatch");
        $finish;
    end

    // watch both sides of the block at each rising edge; values read here are the ones
    // from before the edge, so the order of processes within the step does not matter.
    // a verdict is checked before a transaction at the same edge is noted, as a new
    // number may be taken in the very cycle the previous verdict is strobed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_verdict(is_prime);
            if (start && !busy)
                board.note_number(value);
        end
    end

    // mostly small numbers to keep the run short, with some wide ones for the upper bits,
    // products of two factors for composites, and a band near the top where primes are slow
    function automatic number_t pick_number();
        int unsigned kind;
        int unsigned a;
        int unsigned b;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3, 4: return number_t'($urandom_range(0, 255));
            5, 6:          return number_t'($urandom_range(0, 4095));
            7:             return number_t'($urandom);
            8:
            begin
                a = $urandom_range(2, 255);
                b = $urandom_range(2, 255);
                return number_t'(a * b);
            end
            default:       return number_t'($urandom_range(65000, 65535));
        endcase
    endfunction

    // offer one number after an optional idle burst and hold start until the block takes
    // it; with wiggle set the value is scrambled while the block is busy, so the number
    // that finally goes in is whatever sits on the port at the accepting edge
    task automatic send_number(input number_t n, input int unsigned gap, input bit wiggle);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= n;
        do
        begin
            @(posedge clk);
            if (busy && wiggle)
                value <= pick_number();
        end
        while (busy);
    endtask

    // let the monitor catch up with the last edge, then wait for every owed verdict
    task automatic drain_verdicts();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned gap;
        bit          wiggle;

        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners, with the odd idle burst in between
        foreach (corner_values[i])
        begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
            send_number(corner_values[i], gap, 1'b0);
        end

        // hold off until the block has answered everything
        drain_verdicts();

        // random numbers; the closing stretch runs back to back with no idling
        for (int i = 0; i < 100; i++)
        begin
            if (i == 50)
                drain_verdicts();
            gap    = (i < 80 && $urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
            wiggle = (i < 80) && ($urandom_range(0, 3) == 0);
            send_number(pick_number(), gap, wiggle);
        end

        drain_verdicts();
        // idle on to catch any stray strobe
        repeat (40) @(posedge clk);

        if (board.faults == 0 && board.pending() == 0)
            $display("trial_division_prime_test: match");
        else
            $display("trial_division_prime_test: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_datapath.sv
rtl/core/tdpt_ctrl.sv
rtl/core/trial_division_prime_test.sv
bench/tb.sv
